>>> rtl/core/hrpc_pkg.sv
package hrpc_pkg;

   localparam int ETH_HDR_LEN  = 14;
   localparam int IP_HDR_MIN   = 20;
   localparam int TCP_HDR_MIN  = 20;
   localparam int MIN_PAYLOAD  = 7;
   localparam int HEAD_BYTES   = 6;
   localparam int HIST_LEN     = 12;
   localparam int QUEUE_DEPTH  = 2;

   localparam int POS_ETYPE_HI = 12;
   localparam int POS_ETYPE_LO = 13;
   localparam int POS_IHL      = 14;
   localparam int POS_TLEN_HI  = 16;
   localparam int POS_TLEN_LO  = 17;
   localparam int POS_PROTO    = 23;
   localparam int POS_SRC_LO   = 26;
   localparam int POS_SRC_HI   = 29;
   localparam int POS_DST_LO   = 30;
   localparam int POS_DST_HI   = 33;
   localparam int TCP_OFS_POS  = 12;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_D = 8'h44;
   localparam logic [7:0] CHAR_E = 8'h45;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_H = 8'h48;
   localparam logic [7:0] CHAR_L = 8'h4C;
   localparam logic [7:0] CHAR_O = 8'h4F;
   localparam logic [7:0] CHAR_P = 8'h50;
   localparam logic [7:0] CHAR_S = 8'h53;
   localparam logic [7:0] CHAR_T = 8'h54;
   localparam logic [7:0] CHAR_U = 8'h55;

   typedef enum logic [2:0] {
      REASON_PASS      = 3'd0,
      REASON_TRUNCATED = 3'd1,
      REASON_NOT_IPV4  = 3'd2,
      REASON_NOT_TCP   = 3'd3,
      REASON_SHORT     = 3'd4,
      REASON_NO_METHOD = 3'd5
   } reason_type;

   typedef struct packed {
      logic [15:0] ether_type;
      logic [3:0]  ip_words;
      logic [15:0] ip_total_length;
      logic [7:0]  ip_protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] tcp_sport;
      logic [15:0] tcp_dport;
      logic [3:0]  tcp_words;
      logic [47:0] payload_head;
   } frame_info_type;

endpackage

>>> rtl/core/hrpc_parser.sv
module hrpc_parser #(
   parameter int POSITION_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_last_byte,
   input  logic                        queue_full,
   output logic                        push_valid,
   output logic [POSITION_WIDTH:0]     push_length,
   output hrpc_pkg::frame_info_type    push_info
);

   localparam logic [POSITION_WIDTH-1:0] POS_MAX   = '1;
   localparam logic [POSITION_WIDTH-1:0] P_ETYPE_HI = POSITION_WIDTH'(hrpc_pkg::POS_ETYPE_HI);
   localparam logic [POSITION_WIDTH-1:0] P_ETYPE_LO = POSITION_WIDTH'(hrpc_pkg::POS_ETYPE_LO);
   localparam logic [POSITION_WIDTH-1:0] P_IHL      = POSITION_WIDTH'(hrpc_pkg::POS_IHL);
   localparam logic [POSITION_WIDTH-1:0] P_TLEN_HI  = POSITION_WIDTH'(hrpc_pkg::POS_TLEN_HI);
   localparam logic [POSITION_WIDTH-1:0] P_TLEN_LO  = POSITION_WIDTH'(hrpc_pkg::POS_TLEN_LO);
   localparam logic [POSITION_WIDTH-1:0] P_PROTO    = POSITION_WIDTH'(hrpc_pkg::POS_PROTO);
   localparam logic [POSITION_WIDTH-1:0] P_SRC_LO   = POSITION_WIDTH'(hrpc_pkg::POS_SRC_LO);
   localparam logic [POSITION_WIDTH-1:0] P_SRC_HI   = POSITION_WIDTH'(hrpc_pkg::POS_SRC_HI);
   localparam logic [POSITION_WIDTH-1:0] P_DST_LO   = POSITION_WIDTH'(hrpc_pkg::POS_DST_LO);
   localparam logic [POSITION_WIDTH-1:0] P_DST_HI   = POSITION_WIDTH'(hrpc_pkg::POS_DST_HI);
   localparam logic [POSITION_WIDTH-1:0] P_ETH_END  = POSITION_WIDTH'(hrpc_pkg::ETH_HDR_LEN);
   localparam logic [POSITION_WIDTH-1:0] P_TCP_OFS  = POSITION_WIDTH'(hrpc_pkg::TCP_OFS_POS);
   localparam logic [POSITION_WIDTH-1:0] P_ONE      = POSITION_WIDTH'(1);
   localparam logic [POSITION_WIDTH-1:0] P_TWO      = POSITION_WIDTH'(2);
   localparam logic [POSITION_WIDTH-1:0] P_THREE    = POSITION_WIDTH'(3);
   localparam logic [POSITION_WIDTH-1:0] P_HEAD     = POSITION_WIDTH'(hrpc_pkg::HEAD_BYTES);

   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   hrpc_pkg::frame_info_type  info_ff, info_in, info_nxt;
   logic [7:0]                hist_ff [hrpc_pkg::HIST_LEN];
   logic                      accept;
   logic [6:0]                tcp_start;
   logic [7:0]                payload_start;
   logic [POSITION_WIDTH-1:0] ts_pos, ps_pos, pos_off;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      info_nxt      = info_ff;
      payload_start = '0;
      ps_pos        = '0;
      pos_off       = '0;
      if (pos_ff == P_ETYPE_HI || pos_ff == P_ETYPE_LO) begin
         info_nxt.ether_type = {info_ff.ether_type[7:0], req_data_byte};
      end
      if (pos_ff == P_IHL) begin
         info_nxt.ip_words = req_data_byte[3:0];
      end
      if (pos_ff == P_TLEN_HI || pos_ff == P_TLEN_LO) begin
         info_nxt.ip_total_length = {info_ff.ip_total_length[7:0], req_data_byte};
      end
      if (pos_ff == P_PROTO) begin
         info_nxt.ip_protocol = req_data_byte;
      end
      if (pos_ff >= P_SRC_LO && pos_ff <= P_SRC_HI) begin
         info_nxt.src_addr = {info_ff.src_addr[23:0], req_data_byte};
      end
      if (pos_ff >= P_DST_LO && pos_ff <= P_DST_HI) begin
         info_nxt.dst_addr = {info_ff.dst_addr[23:0], req_data_byte};
      end
      tcp_start = 7'(hrpc_pkg::ETH_HDR_LEN) + {1'b0, info_nxt.ip_words, 2'b00};
      ts_pos    = POSITION_WIDTH'(tcp_start);
      if (pos_ff >= P_ETH_END) begin
         if (pos_ff == ts_pos || pos_ff == ts_pos + P_ONE) begin
            info_nxt.tcp_sport = {info_ff.tcp_sport[7:0], req_data_byte};
         end
         if (pos_ff == ts_pos + P_TWO || pos_ff == ts_pos + P_THREE) begin
            info_nxt.tcp_dport = {info_ff.tcp_dport[7:0], req_data_byte};
         end
         if (pos_ff == ts_pos + P_TCP_OFS) begin
            // Payload bytes already seen are recovered from the byte history.
            info_nxt.tcp_words = req_data_byte[7:4];
            case (req_data_byte[7:4])
               4'd0: begin
                  for (int i = 0; i < hrpc_pkg::HEAD_BYTES; i++) begin
                     info_nxt.payload_head[8*i +: 8] = hist_ff[11-i];
                  end
               end
               4'd1: begin
                  for (int i = 0; i < hrpc_pkg::HEAD_BYTES; i++) begin
                     info_nxt.payload_head[8*i +: 8] = hist_ff[7-i];
                  end
               end
               4'd2: begin
                  for (int i = 0; i < 4; i++) begin
                     info_nxt.payload_head[8*i +: 8] = hist_ff[3-i];
                  end
                  info_nxt.payload_head[39:32] = req_data_byte;
               end
               4'd3: begin
                  info_nxt.payload_head[7:0] = req_data_byte;
               end
               default: begin
               end
            endcase
         end else if (pos_ff > ts_pos + P_TCP_OFS) begin
            payload_start = {1'b0, tcp_start} + {2'b00, info_ff.tcp_words, 2'b00};
            ps_pos        = POSITION_WIDTH'(payload_start);
            pos_off       = pos_ff - ps_pos;
            if (pos_ff >= ps_pos && pos_off < P_HEAD) begin
               for (int i = 0; i < hrpc_pkg::HEAD_BYTES; i++) begin
                  if (pos_off[2:0] == 3'(i)) begin
                     info_nxt.payload_head[8*i +: 8] = req_data_byte;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      if (req_last_byte) begin
         pos_in  = '0;
         info_in = '0;
      end else begin
         pos_in  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + P_ONE;
         info_in = info_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         info_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         info_ff <= info_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hist_ff[0] <= req_data_byte;
         for (int k = 1; k < hrpc_pkg::HIST_LEN; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
      end
   end

   assign push_valid  = accept && req_last_byte;
   assign push_length = {1'b0, pos_ff} + {{POSITION_WIDTH{1'b0}}, 1'b1};
   assign push_info   = info_nxt;

endmodule

>>> rtl/core/hrpc_queue.sv
module hrpc_queue #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  full,
   input  logic                  pop_ready,
   output logic                  pop_valid,
   output logic [DATA_WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [DATA_WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/hrpc_verdict.sv
module hrpc_verdict #(
   parameter int POSITION_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     frame_valid,
   output logic                     frame_ready,
   input  logic [POSITION_WIDTH:0]  frame_length,
   input  hrpc_pkg::frame_info_type frame_info,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_pass,
   output logic [2:0]               rsp_reason,
   output logic [31:0]              rsp_source_address,
   output logic [31:0]              rsp_dest_address,
   output logic [15:0]              rsp_source_port,
   output logic [15:0]              rsp_dest_port
);

   localparam int LEN_W = POSITION_WIDTH + 1;

   logic                 rsp_valid_ff;
   logic                 pass_ff;
   hrpc_pkg::reason_type reason_ff, reason;
   logic [31:0]          src_addr_ff, dst_addr_ff;
   logic [15:0]          sport_ff, dport_ff;
   logic                 take, pass, method_ok;
   logic [6:0]           tcp_start;
   logic [7:0]           payload_end;
   logic [7:0]           hdr_sum;
   logic [7:0]           p0, p1, p2, p3, p4, p5;

   assign frame_ready = !rsp_valid_ff || !rsp_stall;
   assign take        = frame_valid && frame_ready;

   assign p0 = frame_info.payload_head[7:0];
   assign p1 = frame_info.payload_head[15:8];
   assign p2 = frame_info.payload_head[23:16];
   assign p3 = frame_info.payload_head[31:24];
   assign p4 = frame_info.payload_head[39:32];
   assign p5 = frame_info.payload_head[47:40];

   always_comb begin
      method_ok =
         (p0 == hrpc_pkg::CHAR_H && p1 == hrpc_pkg::CHAR_T && p2 == hrpc_pkg::CHAR_T &&
          p3 == hrpc_pkg::CHAR_P) ||
         (p0 == hrpc_pkg::CHAR_G && p1 == hrpc_pkg::CHAR_E && p2 == hrpc_pkg::CHAR_T) ||
         (p0 == hrpc_pkg::CHAR_P && p1 == hrpc_pkg::CHAR_O && p2 == hrpc_pkg::CHAR_S &&
          p3 == hrpc_pkg::CHAR_T) ||
         (p0 == hrpc_pkg::CHAR_P && p1 == hrpc_pkg::CHAR_U && p2 == hrpc_pkg::CHAR_T) ||
         (p0 == hrpc_pkg::CHAR_D && p1 == hrpc_pkg::CHAR_E && p2 == hrpc_pkg::CHAR_L &&
          p3 == hrpc_pkg::CHAR_E && p4 == hrpc_pkg::CHAR_T && p5 == hrpc_pkg::CHAR_E) ||
         (p0 == hrpc_pkg::CHAR_H && p1 == hrpc_pkg::CHAR_E && p2 == hrpc_pkg::CHAR_A &&
          p3 == hrpc_pkg::CHAR_D);
   end

   always_comb begin
      tcp_start   = 7'(hrpc_pkg::ETH_HDR_LEN) + {1'b0, frame_info.ip_words, 2'b00};
      payload_end = {1'b0, tcp_start} + {2'b00, frame_info.tcp_words, 2'b00} +
                    8'(hrpc_pkg::MIN_PAYLOAD);
      // A negative payload length counts as too short.
      hdr_sum     = {2'b00, frame_info.ip_words, 2'b00} + {2'b00, frame_info.tcp_words, 2'b00} +
                    8'(hrpc_pkg::MIN_PAYLOAD);
      if (frame_length < LEN_W'(hrpc_pkg::ETH_HDR_LEN)) begin
         reason = hrpc_pkg::REASON_TRUNCATED;
      end else if (frame_info.ether_type != hrpc_pkg::ETHERTYPE_IPV4) begin
         reason = hrpc_pkg::REASON_NOT_IPV4;
      end else if (frame_length < LEN_W'(hrpc_pkg::ETH_HDR_LEN + hrpc_pkg::IP_HDR_MIN)) begin
         reason = hrpc_pkg::REASON_TRUNCATED;
      end else if (frame_info.ip_protocol != hrpc_pkg::PROTO_TCP) begin
         reason = hrpc_pkg::REASON_NOT_TCP;
      end else if (frame_length < LEN_W'(tcp_start) + LEN_W'(hrpc_pkg::TCP_HDR_MIN)) begin
         reason = hrpc_pkg::REASON_TRUNCATED;
      end else if (frame_info.ip_total_length < {8'h00, hdr_sum}) begin
         reason = hrpc_pkg::REASON_SHORT;
      end else if (frame_length < LEN_W'(payload_end)) begin
         reason = hrpc_pkg::REASON_SHORT;
      end else if (!method_ok) begin
         reason = hrpc_pkg::REASON_NO_METHOD;
      end else begin
         reason = hrpc_pkg::REASON_PASS;
      end
      pass = (reason == hrpc_pkg::REASON_PASS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pass_ff     <= pass;
         reason_ff   <= reason;
         src_addr_ff <= pass ? frame_info.src_addr : '0;
         dst_addr_ff <= pass ? frame_info.dst_addr : '0;
         sport_ff    <= pass ? frame_info.tcp_sport : '0;
         dport_ff    <= pass ? frame_info.tcp_dport : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pass           = pass_ff;
   assign rsp_reason         = reason_ff;
   assign rsp_source_address = src_addr_ff;
   assign rsp_dest_address   = dst_addr_ff;
   assign rsp_source_port    = sport_ff;
   assign rsp_dest_port      = dport_ff;

endmodule

>>> rtl/core/http_request_packet_classifier.sv
// Classifies Ethernet frames for HTTP requests over IPv4 and TCP. Frame bytes enter one per
// clock on the req_ channel unless req_stall holds them, starting at the destination address,
// and the final byte carries req_last_byte; every cycle may carry a byte. A parser captures
// the header fields as the bytes stream past and, on the final byte, hands the frame's fields
// to a two-entry queue; a verdict stage then registers them and gives one rsp_ transaction
// per frame, with pass set or a drop reason, and the flow key zeroed on a drop. The input is
// stalled only while the queue holds two frames awaiting a verdict, so a sustained rate of one
// byte per clock is kept for frames of any length while rsp_stall stays low.
module http_request_packet_classifier #(
   parameter int POSITION_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_pass,
   output logic [2:0]  rsp_reason,
   output logic [31:0] rsp_source_address,
   output logic [31:0] rsp_dest_address,
   output logic [15:0] rsp_source_port,
   output logic [15:0] rsp_dest_port
);

   localparam int INFO_W  = $bits(hrpc_pkg::frame_info_type);
   localparam int ENTRY_W = INFO_W + POSITION_WIDTH + 1;

   logic                     push_valid, queue_full, pop_valid, pop_ready;
   logic [POSITION_WIDTH:0]  push_length, pop_length;
   hrpc_pkg::frame_info_type push_info, pop_info;
   logic [ENTRY_W-1:0]       push_data, pop_data;

   hrpc_parser #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .queue_full    (queue_full),
      .push_valid    (push_valid),
      .push_length   (push_length),
      .push_info     (push_info)
   );

   assign push_data = {push_length, push_info};

   hrpc_queue #(
      .DATA_WIDTH(ENTRY_W),
      .DEPTH     (hrpc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   assign pop_length = pop_data[ENTRY_W-1:INFO_W];
   assign pop_info   = pop_data[INFO_W-1:0];

   hrpc_verdict #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_verdict (
      .clock              (clock),
      .reset              (reset),
      .frame_valid        (pop_valid),
      .frame_ready        (pop_ready),
      .frame_length       (pop_length),
      .frame_info         (pop_info),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pass           (rsp_pass),
      .rsp_reason         (rsp_reason),
      .rsp_source_address (rsp_source_address),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_source_port    (rsp_source_port),
      .rsp_dest_port      (rsp_dest_port)
   );

endmodule

>>> rtl/core/hrpc_checker.sv
module hrpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_pass,
   input logic [2:0]  rsp_reason,
   input logic [31:0] rsp_source_address,
   input logic [31:0] rsp_dest_address,
   input logic [15:0] rsp_source_port,
   input logic [15:0] rsp_dest_port
);

   // A stalled transaction keeps its verdict and flow key.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pass) && $stable(rsp_reason) &&
         $stable(rsp_source_address) && $stable(rsp_dest_address) &&
         $stable(rsp_source_port) && $stable(rsp_dest_port))
      else $error("verdict changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pass == (rsp_reason == hrpc_pkg::REASON_PASS)))
      else $error("pass flag disagrees with the reason code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pass |-> rsp_source_address == '0 && rsp_dest_address == '0 &&
         rsp_source_port == '0 && rsp_dest_port == '0)
      else $error("dropped frame carries a flow key");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reason <= hrpc_pkg::REASON_NO_METHOD)
      else $error("reason code out of range");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result presented straight after reset");

endmodule

bind http_request_packet_classifier hrpc_checker u_hrpc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_pass           (rsp_pass),
   .rsp_reason         (rsp_reason),
   .rsp_source_address (rsp_source_address),
   .rsp_dest_address   (rsp_dest_address),
   .rsp_source_port    (rsp_source_port),
   .rsp_dest_port      (rsp_dest_port)
);

>>> test/http_request_packet_classifier_checker.sv
`timescale 1ns / 100ps

module http_request_packet_classifier_checker
   import hrpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_pass,
   input  logic [2:0]  rsp_reason,
   input  logic [31:0] rsp_source_address,
   input  logic [31:0] rsp_dest_address,
   input  logic [15:0] rsp_source_port,
   input  logic [15:0] rsp_dest_port,
   output int          mismatch_count,
   output int          verdicts_pending
);

   typedef struct {
      logic        pass;
      reason_type  reason;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
   } verdict_type;

   verdict_type expected_verdicts[$];

   logic [15:0] byte_index;
   logic [15:0] ether_type;
   logic [3:0]  ihl;
   logic [15:0] total_length;
   logic [7:0]  protocol;
   logic [31:0] src_ip;
   logic [31:0] dst_ip;
   logic [15:0] src_tcp_port;
   logic [15:0] dst_tcp_port;
   logic [3:0]  data_offset;
   logic [7:0]  payload_start [HEAD_BYTES];
   logic [7:0]  byte_history [HIST_LEN];

   function automatic void clear_frame();
      byte_index = '0;
      ether_type = '0;
      ihl = '0;
      total_length = '0;
      protocol = '0;
      src_ip = '0;
      dst_ip = '0;
      src_tcp_port = '0;
      dst_tcp_port = '0;
      data_offset = '0;
      foreach (payload_start[i]) payload_start[i] = '0;
      foreach (byte_history[i]) byte_history[i] = '0;
   endfunction

   function automatic void parse_byte(input logic [7:0] b, input logic last);
      int pos;
      int tcp_start;
      int data_start;
      int frame_len;
      int payload_len;
      int i;
      int k;
      logic method_ok;
      verdict_type v;
      pos = int'(byte_index);
      if (pos == POS_ETYPE_HI || pos == POS_ETYPE_LO) ether_type = {ether_type[7:0], b};
      if (pos == POS_IHL) ihl = b[3:0];
      if (pos == POS_TLEN_HI || pos == POS_TLEN_LO) total_length = {total_length[7:0], b};
      if (pos == POS_PROTO) protocol = b;
      if (pos >= POS_SRC_LO && pos <= POS_SRC_HI) src_ip = {src_ip[23:0], b};
      if (pos >= POS_DST_LO && pos <= POS_DST_HI) dst_ip = {dst_ip[23:0], b};
      if (pos >= ETH_HDR_LEN) begin
         tcp_start = ETH_HDR_LEN + 4 * int'(ihl);
         if (pos == tcp_start || pos == tcp_start + 1) begin
            src_tcp_port = {src_tcp_port[7:0], b};
         end
         if (pos == tcp_start + 2 || pos == tcp_start + 3) begin
            dst_tcp_port = {dst_tcp_port[7:0], b};
         end
         if (pos == tcp_start + TCP_OFS_POS) begin
            data_offset = b[7:4];
            data_start = tcp_start + 4 * int'(data_offset);
            // Payload bytes that came before the data offset byte are taken from the history.
            for (i = 0; i < HEAD_BYTES; i++) begin
               if (data_start + i < pos) begin
                  k = pos - 1 - (data_start + i);
                  if (k < HIST_LEN) payload_start[i] = byte_history[k];
               end else if (data_start + i == pos) begin
                  payload_start[i] = b;
               end
            end
         end else if (pos > tcp_start + TCP_OFS_POS) begin
            data_start = tcp_start + 4 * int'(data_offset);
            if (pos >= data_start && pos < data_start + HEAD_BYTES) begin
               payload_start[pos - data_start] = b;
            end
         end
      end
      for (i = HIST_LEN - 1; i > 0; i--) byte_history[i] = byte_history[i - 1];
      byte_history[0] = b;
      if (byte_index != '1) byte_index = byte_index + 16'd1;

      if (last) begin
         frame_len = pos + 1;
         tcp_start = ETH_HDR_LEN + 4 * int'(ihl);
         data_start = tcp_start + 4 * int'(data_offset);
         payload_len = int'(total_length) - 4 * int'(ihl) - 4 * int'(data_offset);
         method_ok =
            (payload_start[0] == CHAR_H && payload_start[1] == CHAR_T &&
             payload_start[2] == CHAR_T && payload_start[3] == CHAR_P) ||
            (payload_start[0] == CHAR_G && payload_start[1] == CHAR_E &&
             payload_start[2] == CHAR_T) ||
            (payload_start[0] == CHAR_P && payload_start[1] == CHAR_O &&
             payload_start[2] == CHAR_S && payload_start[3] == CHAR_T) ||
            (payload_start[0] == CHAR_P && payload_start[1] == CHAR_U &&
             payload_start[2] == CHAR_T) ||
            (payload_start[0] == CHAR_D && payload_start[1] == CHAR_E &&
             payload_start[2] == CHAR_L && payload_start[3] == CHAR_E &&
             payload_start[4] == CHAR_T && payload_start[5] == CHAR_E) ||
            (payload_start[0] == CHAR_H && payload_start[1] == CHAR_E &&
             payload_start[2] == CHAR_A && payload_start[3] == CHAR_D);
         if (frame_len < ETH_HDR_LEN) v.reason = REASON_TRUNCATED;
         else if (ether_type != ETHERTYPE_IPV4) v.reason = REASON_NOT_IPV4;
         else if (frame_len < ETH_HDR_LEN + IP_HDR_MIN) v.reason = REASON_TRUNCATED;
         else if (protocol != PROTO_TCP) v.reason = REASON_NOT_TCP;
         else if (frame_len < tcp_start + TCP_HDR_MIN) v.reason = REASON_TRUNCATED;
         else if (payload_len < MIN_PAYLOAD) v.reason = REASON_SHORT;
         else if (frame_len < data_start + MIN_PAYLOAD) v.reason = REASON_SHORT;
         else if (!method_ok) v.reason = REASON_NO_METHOD;
         else v.reason = REASON_PASS;
         v.pass = (v.reason == REASON_PASS);
         v.source_address = v.pass ? src_ip : '0;
         v.dest_address = v.pass ? dst_ip : '0;
         v.source_port = v.pass ? src_tcp_port : '0;
         v.dest_port = v.pass ? dst_tcp_port : '0;
         expected_verdicts.push_back(v);
         clear_frame();
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endfunction

   initial begin
      mismatch_count = 0;
      verdicts_pending = 0;
      clear_frame();
   end

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         clear_frame();
         expected_verdicts.delete();
      end else begin
         if (req_valid && !req_stall) parse_byte(req_data_byte, req_last_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               mismatch_count++;
               $display("%0t: verdict transaction expected none, actual reason %0d", $time,
                        rsp_reason);
            end else begin
               want = expected_verdicts.pop_front();
               check_field("rsp_pass", 32'(want.pass), 32'(rsp_pass));
               check_field("rsp_reason", 32'(want.reason), 32'(rsp_reason));
               check_field("rsp_source_address", want.source_address, rsp_source_address);
               check_field("rsp_dest_address", want.dest_address, rsp_dest_address);
               check_field("rsp_source_port", 32'(want.source_port), 32'(rsp_source_port));
               check_field("rsp_dest_port", 32'(want.dest_port), 32'(rsp_dest_port));
            end
         end
      end
      verdicts_pending = expected_verdicts.size();
   end

endmodule

>>> test/tb_http_request_packet_classifier.sv
`timescale 1ns / 100ps

module tb_http_request_packet_classifier;
   import hrpc_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int TOTAL_BYTES     = 1650;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef enum int {
      METHOD_HTTP,
      METHOD_GET,
      METHOD_POST,
      METHOD_PUT,
      METHOD_DELETE,
      METHOD_HEAD,
      METHOD_NEAR_MISS,
      METHOD_GARBAGE
   } method_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_pass;
   logic [2:0]  rsp_reason;
   logic [31:0] rsp_source_address;
   logic [31:0] rsp_dest_address;
   logic [15:0] rsp_source_port;
   logic [15:0] rsp_dest_port;
   int          mismatch_count;
   int          verdicts_pending;

   logic [7:0]  frame_q[$];
   logic        hold_off_request;
   bit          gappy;
   int          burst_left;
   int          frames_sent;
   int          bytes_sent;
   int          cycle_count = 0;

   http_request_packet_classifier i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pass           (rsp_pass),
      .rsp_reason         (rsp_reason),
      .rsp_source_address (rsp_source_address),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_source_port    (rsp_source_port),
      .rsp_dest_port      (rsp_dest_port)
   );

   http_request_packet_classifier_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pass           (rsp_pass),
      .rsp_reason         (rsp_reason),
      .rsp_source_address (rsp_source_address),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_source_port    (rsp_source_port),
      .rsp_dest_port      (rsp_dest_port),
      .mismatch_count     (mismatch_count),
      .verdicts_pending   (verdicts_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      stall_mode_type mode;
      int mode_left;
      rsp_stall = 1'b0;
      mode = STALL_NONE;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = stall_mode_type'($urandom_range(STALL_NONE, STALL_PERIODIC));
               mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            case (mode)
               STALL_NONE: rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 30);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 85);
               default: rsp_stall <= ((mode_left % 7) < 3);
            endcase
         end
      end
   end

   function automatic string method_text(input method_type method);
      case (method)
         METHOD_HTTP: return "HTTP/1.1";
         METHOD_GET: return "GET /idx";
         METHOD_POST: return "POST /up";
         METHOD_PUT: return "PUT /abc";
         METHOD_DELETE: return "DELETE /";
         METHOD_HEAD: return "HEAD /xy";
         METHOD_NEAR_MISS: begin
            case ($urandom_range(0, 7))
               0: return "HTTQ/1.1";
               1: return "GEt /idx";
               2: return "POSt /up";
               3: return "PUX /abc";
               4: return "DELETF /";
               5: return "DELEE /x";
               6: return "HEAX /xy";
               default: return "get /idx";
            endcase
         end
         default: return "";
      endcase
   endfunction

   task automatic build_frame(input logic [15:0] etype, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [3:0] doff,
                              input method_type method, input int pay_len,
                              input int tlen_slack);
      int tcp_start;
      int data_start;
      int frame_len;
      int ip_len;
      int i;
      logic [3:0] version;
      logic [3:0] flags;
      string text;
      tcp_start = ETH_HDR_LEN + 4 * int'(ihl);
      data_start = tcp_start + 4 * int'(doff);
      frame_len = data_start + pay_len;
      if (frame_len < tcp_start + TCP_HDR_MIN) frame_len = tcp_start + TCP_HDR_MIN;
      ip_len = 4 * int'(ihl) + 4 * int'(doff) + pay_len + tlen_slack;
      if (ip_len < 0) ip_len = 0;
      if (ip_len > 65535) ip_len = 65535;
      version = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 1)) version = 4'h4;
      flags = 4'($urandom_range(0, 15));
      text = method_text(method);
      frame_q.delete();
      for (i = 0; i < frame_len; i++) frame_q.push_back(8'($urandom_range(0, 255)));
      for (i = 0; i < text.len() && data_start + i < frame_len; i++) begin
         frame_q[data_start + i] = text[i];
      end
      frame_q[POS_ETYPE_HI] = etype[15:8];
      frame_q[POS_ETYPE_LO] = etype[7:0];
      frame_q[POS_IHL] = {version, ihl};
      frame_q[POS_TLEN_HI] = ip_len[15:8];
      frame_q[POS_TLEN_LO] = ip_len[7:0];
      frame_q[POS_PROTO] = proto;
      frame_q[tcp_start + TCP_OFS_POS] = {doff, flags};
   endtask

   task automatic build_raw_frame(input int frame_len, input int fill);
      int i;
      frame_q.delete();
      for (i = 0; i < frame_len; i++) begin
         if (fill < 0) frame_q.push_back(8'($urandom_range(0, 255)));
         else frame_q.push_back(fill[7:0]);
      end
   endtask

   task automatic trim_frame(input int frame_len);
      while (frame_q.size() > frame_len) void'(frame_q.pop_back());
   endtask

   task automatic idle(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic put_byte(input logic [7:0] value, input logic last);
      req_valid <= 1'b1;
      req_data_byte <= value;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_q.size(); i++) begin
         if (gappy && burst_left == 0) begin
            idle($urandom_range(1, 6));
            burst_left = $urandom_range(1, 20);
         end
         if (burst_left > 0) burst_left--;
         put_byte(frame_q[i], i == frame_q.size() - 1);
      end
      frames_sent++;
      bytes_sent += frame_q.size();
   endtask

   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      @(negedge clock);
      while (verdicts_pending != 0) @(negedge clock);
   endtask

   initial begin
      int scenario;
      int pay_len;
      int slack;
      int i;
      bit cut;
      logic [15:0] etype;
      logic [3:0] ihl;
      logic [3:0] doff;
      logic [7:0] proto;
      method_type method;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_last_byte = 1'b0;
      hold_off_request = 1'b0;
      gappy = 1'b0;
      burst_left = 0;
      frames_sent = 0;
      bytes_sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = METHOD_HTTP; i <= METHOD_HEAD; i++) begin
         gappy = i[0];
         build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, method_type'(i), 16, 0);
         send_frame();
      end
      gappy = 1'b1;
      build_frame(ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 4'd15, METHOD_HEAD, MIN_PAYLOAD, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, METHOD_GET, MIN_PAYLOAD - 1, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, METHOD_GET, MIN_PAYLOAD - 1, 1);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, METHOD_POST, 12, -200);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, METHOD_NEAR_MISS, 12, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 4'd6, PROTO_TCP, 4'd7, METHOD_NEAR_MISS, 12, 0);
      send_frame();
      build_frame(16'h86DD, 4'd5, PROTO_TCP, 4'd5, METHOD_GET, 12, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 4'd5, 8'd17, 4'd5, METHOD_GET, 12, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 4'd0, PROTO_TCP, 4'd0, METHOD_GET, 12, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd1, METHOD_GET, 16, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd2, METHOD_PUT, 16, 0);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 4'd3, PROTO_TCP, 4'd3, METHOD_HTTP, 16, 4);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, METHOD_GET, 16, 0);
      trim_frame(ETH_HDR_LEN - 1);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, METHOD_GET, 16, 0);
      trim_frame(ETH_HDR_LEN + IP_HDR_MIN - 1);
      send_frame();
      build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, METHOD_GET, 16, 0);
      trim_frame(ETH_HDR_LEN + IP_HDR_MIN + TCP_HDR_MIN - 1);
      send_frame();
      build_raw_frame(1, -1);
      send_frame();
      build_raw_frame(60, 8'h00);
      send_frame();
      build_raw_frame(60, 8'hFF);
      send_frame();
      wait_for_verdicts();

      hold_off_request = 1'b1;
      for (i = 0; i < 10; i++) begin
         build_raw_frame($urandom_range(1, 24), -1);
         send_frame();
      end
      wait_for_verdicts();

      while (bytes_sent < TOTAL_BYTES) begin
         etype = ETHERTYPE_IPV4;
         proto = PROTO_TCP;
         ihl = 4'd5;
         doff = 4'd5;
         if ($urandom_range(0, 1)) ihl = 4'($urandom_range(5, 15));
         if ($urandom_range(0, 1)) doff = 4'($urandom_range(5, 15));
         method = method_type'($urandom_range(METHOD_HTTP, METHOD_HEAD));
         pay_len = $urandom_range(MIN_PAYLOAD, 24);
         slack = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 0;
         cut = 1'b0;
         scenario = $urandom_range(0, 99);
         if (scenario >= 65 && scenario < 70) begin
            ihl = 4'($urandom_range(0, 4));
            doff = 4'($urandom_range(0, 4));
         end else if (scenario >= 70 && scenario < 75) begin
            if ($urandom_range(0, 1)) etype = 16'($urandom_range(0, 65535));
            else etype = ETHERTYPE_IPV4 ^ (16'h0001 << $urandom_range(0, 15));
         end else if (scenario >= 75 && scenario < 80) begin
            if ($urandom_range(0, 1)) proto = 8'($urandom_range(0, 255));
            else proto = PROTO_TCP ^ (8'h01 << $urandom_range(0, 7));
         end else if (scenario >= 80 && scenario < 85) begin
            method = $urandom_range(0, 1) ? METHOD_NEAR_MISS : METHOD_GARBAGE;
         end else if (scenario >= 85 && scenario < 90) begin
            pay_len = $urandom_range(0, MIN_PAYLOAD + 1);
            slack = -$urandom_range(0, 100);
         end else if (scenario >= 90 && scenario < 95) begin
            cut = 1'b1;
         end
         if (scenario >= 95) build_raw_frame($urandom_range(1, 80), -1);
         else build_frame(etype, ihl, proto, doff, method, pay_len, slack);
         if (cut) trim_frame($urandom_range(1, frame_q.size()));
         gappy = ($urandom_range(0, 3) != 0);
         send_frame();
         if ($urandom_range(0, 4) == 0) idle($urandom_range(1, 10));
         if (frames_sent % 16 == 0) wait_for_verdicts();
      end

      wait_for_verdicts();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && verdicts_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/hrpc_pkg.sv
rtl/core/hrpc_parser.sv
rtl/core/hrpc_queue.sv
rtl/core/hrpc_verdict.sv
rtl/core/http_request_packet_classifier.sv
rtl/core/hrpc_checker.sv
test/http_request_packet_classifier_checker.sv
test/tb_http_request_packet_classifier.sv
